FILE: sv/byte_ring_buffer_burst_top_defines.svh
// ---------------------------------------------------------------------------
// Byte ring buffer assertion macros
// Check macros for the byte ring buffer datapath.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_BURST_TOP_DEFINES_SVH
`define BYTE_RING_BUFFER_BURST_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define BRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/brb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring buffer package
// Word types, kind codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package brb_pkg;

  // Width of capacity, counts and ring pointers
  localparam int CNT_W = 11;

  // Item kinds
  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_PEEK  = 3'd2;
  localparam logic [2:0] KIND_INDEX = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // Input word
  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] burst_len;
    logic             first_byte;
    logic             last_byte;
    logic [9:0]       offset;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic [CNT_W-1:0] done_count;
    logic             last;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] free_count;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch input word
    logic cfg_wr;      // capacity write, empties ring
    logic do_write;    // write-byte item
    logic rd_start;    // read/peek of one or more bytes
    logic rd_issue;    // issue one byte read
    logic idx_read;    // indexed read that hits
    logic emit_empty;  // single result without a byte
    logic clear;       // empty the ring
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] kind;
    logic       n_zero;    // read/peek delivers nothing
    logic       idx_hit;   // offset below fill
    logic       cnt_last;  // final byte read being issued
  } dp_stat_t;

endpackage

FILE: sv/brb_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring buffer RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/brb_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring buffer controller
// Sequences one item at a time: decode, byte reads, drain of the read pipe.
// ---------------------------------------------------------------------------
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              cfg_valid,
  input  brb_pkg::dp_stat_t stat,
  output logic              busy,
  output logic              cfg_ready,
  output brb_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if ((stat.kind == brb_pkg::KIND_READ) || (stat.kind == brb_pkg::KIND_PEEK)) begin
          if (!stat.n_zero) begin
            state_nxt = S_READ;
          end
        end else if (stat.kind == brb_pkg::KIND_INDEX) begin
          if (stat.idx_hit) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_READ: begin
        if (stat.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load   = start;
        cmd.cfg_wr = cfg_valid;
      end
      S_DECODE: begin
        case (stat.kind)
          brb_pkg::KIND_WRITE: begin
            cmd.do_write = 1'b1;
          end
          brb_pkg::KIND_READ, brb_pkg::KIND_PEEK: begin
            cmd.rd_start   = !stat.n_zero;
            cmd.emit_empty = stat.n_zero;
          end
          brb_pkg::KIND_INDEX: begin
            cmd.idx_read   = stat.idx_hit;
            cmd.emit_empty = !stat.idx_hit;
          end
          brb_pkg::KIND_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            cmd = '0;
          end
        endcase
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

endmodule

FILE: sv/brb_dp.sv
`timescale 1ns / 1ps
`include "byte_ring_buffer_burst_top_defines.svh"
// ---------------------------------------------------------------------------
// Byte ring buffer datapath
// Ring pointers, fill count, burst tracking, byte RAM and result register.
// ---------------------------------------------------------------------------
module brb_dp #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brb_pkg::ctl_cmd_t             cmd,
  input  brb_pkg::in_word_t             in_data,
  input  logic [brb_pkg::CNT_W-1:0]     cfg_data,
  output brb_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  output brb_pkg::out_word_t            out_data
);

  localparam int CW      = brb_pkg::CNT_W;
  localparam int AW      = $clog2(DEPTH);
  localparam int NW      = $clog2(MAX_READ + 1);
  localparam int CAP_MAX = (DEPTH > 2047) ? 2047 : DEPTH;
  localparam int CAP_RST = (DEPTH > 1024) ? 1024 : DEPTH;

  // Ring state
  logic [CW-1:0] cap_r, cap_nxt;
  logic [CW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic          acc_r, acc_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] done_r, done_nxt;

  // Item and read sequencing
  brb_pkg::in_word_t item_r;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          pend_r, pend_last_r, pend_idx_r;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  brb_pkg::out_word_t out_r, out_nxt;

  // RAM
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] ram_raddr;

  // Read length: min(len, held, MAX_READ)
  logic [CW-1:0] len_min;
  logic [NW-1:0] n_calc;
  assign len_min = (item_r.burst_len < held_r) ? item_r.burst_len : held_r;
  assign n_calc  = (32'(len_min) > MAX_READ) ? NW'(MAX_READ) : NW'(len_min);

  // Wrapped pointer sums
  logic [CW:0]   rd_sum, idx_sum;
  logic [CW-1:0] rd_wrap, idx_addr, scan_inc, wr_inc;
  assign rd_sum   = {1'b0, rd_ptr_r} + {{(CW + 1 - NW){1'b0}}, n_calc};
  assign rd_wrap  = (rd_sum >= {1'b0, cap_r}) ? CW'(rd_sum - {1'b0, cap_r}) : CW'(rd_sum);
  assign idx_sum  = {1'b0, rd_ptr_r} + {{(CW + 1 - 10){1'b0}}, item_r.offset};
  assign idx_addr = (idx_sum >= {1'b0, cap_r}) ? CW'(idx_sum - {1'b0, cap_r}) : CW'(idx_sum);
  assign scan_inc = (scan_r + 1'b1 == cap_r) ? '0 : scan_r + 1'b1;
  assign wr_inc   = (wr_ptr_r + 1'b1 == cap_r) ? '0 : wr_ptr_r + 1'b1;

  // Burst state after a first byte
  logic          first_ok;
  logic          acc_v;
  logic [CW-1:0] left_v, done_v;
  logic          store_en;
  assign first_ok = (item_r.burst_len != '0) && (item_r.burst_len <= cap_r - held_r);
  assign acc_v    = item_r.first_byte ? first_ok : acc_r;
  assign left_v   = item_r.first_byte ? (first_ok ? item_r.burst_len : '0) : left_r;
  assign done_v   = item_r.first_byte ? '0 : done_r;
  assign store_en = acc_v && (left_v != '0) && (held_r < cap_r);

  // Status to controller
  assign stat.kind     = item_r.kind;
  assign stat.n_zero   = (n_calc == '0);
  assign stat.idx_hit  = ({1'b0, item_r.offset} < held_r);
  assign stat.cnt_last = (cnt_r == n_r - NW'(1));

  assign ram_we    = cmd.do_write && store_en;
  assign ram_raddr = cmd.idx_read ? AW'(idx_addr) : AW'(scan_r);

  // Ring and burst update
  always_comb begin
    cap_nxt    = cap_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    held_nxt   = held_r;
    acc_nxt    = acc_r;
    left_nxt   = left_r;
    done_nxt   = done_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    scan_nxt   = scan_r;
    if (cmd.cfg_wr || cmd.clear) begin
      if (cmd.cfg_wr) begin
        if (cfg_data == '0) begin
          cap_nxt = CW'(1);
        end else if (32'(cfg_data) > CAP_MAX) begin
          cap_nxt = CW'(CAP_MAX);
        end else begin
          cap_nxt = cfg_data;
        end
      end
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      held_nxt   = '0;
      acc_nxt    = 1'b0;
      left_nxt   = '0;
      done_nxt   = '0;
    end else if (cmd.do_write) begin
      acc_nxt  = acc_v;
      left_nxt = left_v;
      done_nxt = done_v;
      if (store_en) begin
        wr_ptr_nxt = wr_inc;
        held_nxt   = held_r + 1'b1;
        left_nxt   = left_v - 1'b1;
        done_nxt   = done_v + 1'b1;
      end
      if (item_r.last_byte) begin
        acc_nxt  = 1'b0;
        left_nxt = '0;
        done_nxt = '0;
      end
    end else if (cmd.rd_start) begin
      n_nxt    = n_calc;
      cnt_nxt  = '0;
      scan_nxt = rd_ptr_r;
      if (item_r.kind == brb_pkg::KIND_READ) begin
        rd_ptr_nxt = rd_wrap;
        held_nxt   = held_r - CW'(n_calc);
      end
    end else if (cmd.rd_issue) begin
      cnt_nxt  = cnt_r + 1'b1;
      scan_nxt = scan_inc;
    end
  end

  // Result assembly
  always_comb begin
    out_valid_nxt    = 1'b0;
    out_nxt          = out_r;
    out_nxt.out_byte   = '0;
    out_nxt.byte_valid = 1'b0;
    out_nxt.done_count = '0;
    out_nxt.last       = 1'b1;
    out_nxt.fill_count = held_nxt;
    out_nxt.free_count = cap_r - held_nxt;
    if (pend_r) begin
      out_valid_nxt      = 1'b1;
      out_nxt.out_byte   = ram_rdata;
      out_nxt.byte_valid = 1'b1;
      out_nxt.done_count = pend_idx_r ? '0 : CW'(n_r);
      out_nxt.last       = pend_last_r;
    end else if (cmd.do_write) begin
      // accepted count reported on the last write byte
      out_valid_nxt      = item_r.last_byte;
      out_nxt.done_count = store_en ? done_v + 1'b1 : done_v;
    end else if (cmd.emit_empty || cmd.clear) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CW'(CAP_RST);
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      held_r      <= '0;
      acc_r       <= 1'b0;
      left_r      <= '0;
      done_r      <= '0;
      n_r         <= '0;
      cnt_r       <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      pend_idx_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      held_r      <= held_nxt;
      acc_r       <= acc_nxt;
      left_r      <= left_nxt;
      done_r      <= done_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= cmd.rd_issue || cmd.idx_read;
      pend_last_r <= cmd.idx_read || (cmd.rd_issue && stat.cnt_last);
      pend_idx_r  <= cmd.idx_read;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  brb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(wr_ptr_r)),
    .wdata (item_r.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `BRB_ASSERT_NOW(a_held_le_cap, 1'b1, held_r <= cap_r, "fill count above capacity")
  `BRB_ASSERT_NOW(a_ptr_in_ring, 1'b1, (rd_ptr_r < cap_r) && (wr_ptr_r < cap_r), "pointer off ring")
  `BRB_ASSERT_NEXT(a_pend_emits, pend_r, out_valid_r && out_r.byte_valid, "read byte not delivered")
  `BRB_ASSERT_NOW(a_issue_len, cmd.rd_issue, (n_r != '0) && (cnt_r < n_r), "byte read past length")

endmodule

FILE: sv/byte_ring_buffer_burst_top.sv
`timescale 1ns / 1ps
// Timing: one item at a time, busy until its last result. Write-byte, clear and empty
//   results are registered from decode; read/peek and indexed bytes pass the registered
//   RAM read and a pending stage. One byte per cycle within a read, set by the single
//   RAM read port. Reset: synchronous active-low rst_n empties the ring and sets
//   capacity to min(DEPTH, 1024); the byte store holds no reset. Results are a one-cycle
//   strobe and cannot be stalled.
// ---------------------------------------------------------------------------
// Byte ring buffer top level
// Circular byte store with burst writes, bounded reads, peeks and indexed reads.
// ---------------------------------------------------------------------------
module byte_ring_buffer_burst_top #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  brb_pkg::in_word_t         in_data,
  output logic                      out_valid,
  output brb_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [brb_pkg::CNT_W-1:0] cfg_data
);

  brb_pkg::ctl_cmd_t cmd;
  brb_pkg::dp_stat_t stat;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  brb_dp #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
